// ----- rtl/euc_to_jis_sjis_transcoder_macros.svh -----
// ----------------------------------------------------------------------------
// euc_to_jis_sjis_transcoder_macros.svh
// Assertion macros used by the transcoder top level.
// ----------------------------------------------------------------------------
`ifndef EUC_TO_JIS_SJIS_TRANSCODER_MACROS_SVH
`define EUC_TO_JIS_SJIS_TRANSCODER_MACROS_SVH

// checked outside reset only
`define EJS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define EJS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ejs_pkg.sv -----
// ----------------------------------------------------------------------------
// ejs_pkg
// Types and constants of the EUC-JP to JIS / Shift_JIS transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ejs_pkg;

  // output_code values; any other value acts as EUC passthrough
  localparam logic [1:0] CODE_EUC  = 2'd0;
  localparam logic [1:0] CODE_JIS  = 2'd1;
  localparam logic [1:0] CODE_SJIS = 2'd2;

  localparam logic [7:0] BYTE_ESC    = 8'h1b;
  localparam logic [7:0] BYTE_DOLLAR = 8'h24;
  localparam logic [7:0] BYTE_PAREN  = 8'h28;
  localparam logic [7:0] BYTE_B      = 8'h42;
  localparam logic [7:0] LEAD_MIN    = 8'h80;

  localparam int unsigned BURST_MAX = 8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } ejs_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_burst;
  } ejs_out_t;

  // all output bytes caused by one input byte, in order
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0]       bytes;
    logic [$clog2(BURST_MAX)-1:0]    last_idx;
  } burst_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- rtl/ejs_front.sv -----
// ----------------------------------------------------------------------------
// ejs_front
// Accepts input bytes, tracks lead/run state and builds each output burst.
// ----------------------------------------------------------------------------
`default_nettype none

module ejs_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_wdata,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ejs_pkg::ejs_in_t in_data,
  input  wire ejs_pkg::q_stat_t q_stat,
  output logic                 q_push,
  output ejs_pkg::burst_t      q_wdata
);
  import ejs_pkg::*;

  logic [1:0] code_r, code_nxt;
  logic       kanji_r, kanji_nxt;
  logic       pend_r, pend_nxt;
  logic [7:0] held_r, held_nxt;

  logic       in_fire;
  logic [7:0] b;
  logic       eos;
  logic       is_hold, is_ascii;
  logic       jis, sjis;
  logic       open_run, close_post, close_pre, kanji_after;
  logic [7:0] lead, trail;
  logic [7:0] hi, lo, s1t, s1, s2;
  logic [8:0] s1w;
  logic [7:0] p0, p1;

  assign in_ready = !q_stat.full;
  assign in_fire  = in_valid && in_ready;
  assign b        = in_data.in_byte;
  assign eos      = in_data.end_of_string;

  always_comb begin
    is_hold  = !pend_r && b[7] && !eos;
    is_ascii = !pend_r && !b[7];
    jis      = (code_r == CODE_JIS);
    sjis     = (code_r == CODE_SJIS);
    lead     = pend_r ? held_r : b;
    trail    = pend_r ? b : 8'h00;

    // pair minus 0x8080 as a 16-bit code, then the JIS to Shift_JIS map
    hi  = lead - LEAD_MIN - {7'd0, ~trail[7]};
    lo  = trail ^ LEAD_MIN;
    s1t = hi - 8'h21;
    s1w = {2'b00, s1t[7:1]} + 9'h081;
    s1  = (s1w > 9'h09f) ? (s1w[7:0] + 8'h40) : s1w[7:0];
    if (hi[0]) begin
      s2 = lo + 8'h1f + {7'd0, (lo > 8'h5f)};
    end else begin
      s2 = lo + 8'h7e;
    end

    if (jis) begin
      p0 = lead ^ LEAD_MIN;
      p1 = trail ^ LEAD_MIN;
    end else if (sjis) begin
      p0 = s1;
      p1 = s2;
    end else begin
      p0 = lead;
      p1 = trail;
    end

    open_run    = jis && !kanji_r;
    kanji_after = kanji_r || jis;
    close_post  = eos && kanji_after;
    close_pre   = kanji_r;

    q_wdata = '0;
    if (is_ascii) begin
      if (close_pre) begin
        q_wdata.bytes[0] = BYTE_ESC;
        q_wdata.bytes[1] = BYTE_PAREN;
        q_wdata.bytes[2] = BYTE_B;
        q_wdata.bytes[3] = b;
        q_wdata.last_idx = 3'd3;
      end else begin
        q_wdata.bytes[0] = b;
        q_wdata.last_idx = 3'd0;
      end
    end else if (open_run) begin
      q_wdata.bytes[0] = BYTE_ESC;
      q_wdata.bytes[1] = BYTE_DOLLAR;
      q_wdata.bytes[2] = BYTE_B;
      q_wdata.bytes[3] = p0;
      q_wdata.bytes[4] = p1;
      q_wdata.last_idx = 3'd4;
      if (close_post) begin
        q_wdata.bytes[5] = BYTE_ESC;
        q_wdata.bytes[6] = BYTE_PAREN;
        q_wdata.bytes[7] = BYTE_B;
        q_wdata.last_idx = 3'd7;
      end
    end else begin
      q_wdata.bytes[0] = p0;
      q_wdata.bytes[1] = p1;
      q_wdata.last_idx = 3'd1;
      if (close_post) begin
        q_wdata.bytes[2] = BYTE_ESC;
        q_wdata.bytes[3] = BYTE_PAREN;
        q_wdata.bytes[4] = BYTE_B;
        q_wdata.last_idx = 3'd4;
      end
    end

    q_push = in_fire && !is_hold;
  end

  always_comb begin
    code_nxt  = cfg_we ? cfg_wdata : code_r;
    kanji_nxt = kanji_r;
    pend_nxt  = pend_r;
    held_nxt  = held_r;
    if (in_fire) begin
      pend_nxt = is_hold;
      if (is_hold) begin
        held_nxt = b;
      end else if (is_ascii) begin
        kanji_nxt = 1'b0;
      end else begin
        kanji_nxt = eos ? 1'b0 : kanji_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r  <= CODE_EUC;
      kanji_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      code_r  <= code_nxt;
      kanji_r <= kanji_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // hold the lead byte; only read while a lead is pending
  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/ejs_queue.sv -----
// ----------------------------------------------------------------------------
// ejs_queue
// Small FIFO of output bursts between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ejs_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire ejs_pkg::burst_t wdata,
  input  wire logic            pop,
  output ejs_pkg::burst_t      rdata,
  output ejs_pkg::q_stat_t     stat
);
  import ejs_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  burst_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ejs_back.sv -----
// ----------------------------------------------------------------------------
// ejs_back
// Walks the head burst into the output register one byte per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ejs_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ejs_pkg::q_stat_t q_stat,
  input  wire ejs_pkg::burst_t  q_rdata,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ejs_pkg::ejs_out_t     out_data
);
  import ejs_pkg::*;

  localparam int unsigned POS_W = $clog2(BURST_MAX);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             valid_r, valid_nxt;
  ejs_out_t         data_r, data_nxt;
  logic             load, at_last;

  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    load      = !q_stat.empty && (!valid_r || out_ready);
    at_last   = (pos_r == q_rdata.last_idx);
    q_pop     = load && at_last;
    pos_nxt   = pos_r;
    data_nxt  = data_r;
    valid_nxt = valid_r && !out_ready;
    if (load) begin
      // advance within the burst, restart at zero once the last byte goes out
      pos_nxt                = at_last ? '0 : pos_r + 1'b1;
      data_nxt.out_byte      = q_rdata.bytes[pos_r];
      data_nxt.last_of_burst = at_last;
      valid_nxt              = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/euc_to_jis_sjis_transcoder.sv -----
// ----------------------------------------------------------------------------
// euc_to_jis_sjis_transcoder
// EUC-JP byte stream to EUC, ISO-2022-JP or Shift_JIS bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one EUC-JP byte per request with an end-of-string flag.
//   out_* : converted bytes; last_of_burst marks the final byte produced
//           by one input byte.
//   cfg_* : cfg_we writes the 2-bit output code (0 EUC, 1 JIS, 2 SJIS);
//           write only while no bytes are in flight.
//   A lead byte (0x80 and up) waits for its trail unless end_of_string is set.
//   A burst's first byte passes through the queue, then the output register.
//   Input is taken one byte per cycle while in_ready is high; the back end
//   sends one output byte per cycle while out_ready allows, so a burst
//   holds the back end until its last byte is out. Bursts wait in a
//   QUEUE_DEPTH-entry queue, and in_ready drops only when that queue is full.
//   When out_ready is low the output register holds its byte and the queue
//   fills, then the input stalls.
//   Reset: output code EUC, ASCII mode, no held lead, queue and output empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "euc_to_jis_sjis_transcoder_macros.svh"

module euc_to_jis_sjis_transcoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ejs_pkg::ejs_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ejs_pkg::ejs_out_t      out_data
);
  import ejs_pkg::*;

  q_stat_t q_stat;
  logic    q_push, q_pop;
  burst_t  q_wdata, q_rdata;

  ejs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  ejs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  ejs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `EJS_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "output valid after reset")
  `EJS_ASSERT(a_no_push_when_full, q_push |-> !q_stat.full, "burst pushed into full queue")
  `EJS_ASSERT(a_empty_idle_stays, (q_stat.empty && !out_valid) |=> !out_valid, "output without burst")
  `EJS_ASSERT(a_pop_only_nonempty, q_pop |-> !q_stat.empty, "pop from empty queue")

endmodule

`default_nettype wire
